@@ rtl/mroe_pkg.sv @@
package mroe_pkg;

  localparam int DATA_W = 32;
  localparam int ROW_W = 4;
  localparam int COL_W = 4;
  localparam int CFG_W = 5;
  localparam int CFG_IDX_W = 1;

  localparam int MAX_ROWS_DEF = 16;
  localparam int MAX_COLS_DEF = 16;

  localparam logic [CFG_W-1:0] ROWS_RESET = 5'd16;
  localparam logic [CFG_W-1:0] COLS_RESET = 5'd16;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_SWAP  = 2'd2,
    OP_SCALE = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS = 1'b0,
    REG_COLS = 1'b1
  } reg_idx_t;

endpackage

@@ rtl/mroe_mem.sv @@
module mroe_mem #(
  parameter int DEPTH = 256,
  parameter int AW = 8
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [mroe_pkg::DATA_W-1:0] wdata,
  input  logic [AW-1:0]               raddr0,
  input  logic [AW-1:0]               raddr1,
  output logic [mroe_pkg::DATA_W-1:0] q0,
  output logic [mroe_pkg::DATA_W-1:0] q1
);
  import mroe_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    q0 <= mem[raddr0];
    q1 <= mem[raddr1];
  end

endmodule

@@ rtl/mroe_mul.sv @@
module mroe_mul (
  input  logic                               clk,
  input  logic signed [mroe_pkg::DATA_W-1:0] elem,
  input  logic signed [mroe_pkg::DATA_W-1:0] mult,
  output logic signed [mroe_pkg::DATA_W-1:0] scaled
);
  import mroe_pkg::*;

  localparam int PW = 2 * DATA_W;
  localparam int QW = PW - 16;

  logic signed [PW-1:0] prod;
  logic signed [QW-1:0] quot;
  logic                 fits;

  always_ff @(posedge clk) begin
    prod <= PW'(elem) * PW'(mult);
  end

  // arithmetic shift rounds toward minus infinity
  assign quot = QW'(prod >>> 16);
  // fits when every bit above the sign position matches the sign
  assign fits = (quot[QW-1:DATA_W-1] == '0) || (quot[QW-1:DATA_W-1] == '1);

  always_comb begin
    if (fits) begin
      scaled = quot[DATA_W-1:0];
    end else if (quot[QW-1]) begin
      scaled = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      scaled = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

endmodule

@@ rtl/matrix_row_operation_engine_top.sv @@
// Matrix row operation engine: a store of Q16.16 elements, MAX_ROWS rows of
// MAX_COLS columns, held in a two-read one-write synchronous memory.
// Input channel (in_valid/in_stall) carries one operation per transaction:
// write element, read element, swap two rows or scale one row by value.
// Output channel (out_valid/out_stall) returns one transaction per operation
// with read_value (zero unless a good read) and status (1 = index out of range).
// Config port: cfg_write with cfg_index 0 sets rows_in_use, 1 sets cols_in_use;
// write it only while no operation is in flight.
// Write and flagged ops go straight to done, read through S_RDATA; swap and scale
// loop over the nc columns in use, skipping the loop when nc is zero. Swap needs
// two memory writes per column on the single write port; scale reads each element
// into the registered multiplier and writes it back, next read overlapped.
// One operation is worked at a time; in_stall is high while one is in work.
// A finished result sits in the output register while the next operation is
// accepted; if out_stall holds it, the following result waits in its own stage.
// Reset (rst, synchronous) returns to idle, drops out_valid and restores both
// sizes to 16. Store contents are not cleared; read only what was written.
module matrix_row_operation_engine_top #(
  parameter int MAX_ROWS = mroe_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = mroe_pkg::MAX_COLS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [mroe_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mroe_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          op,
  input  logic [mroe_pkg::ROW_W-1:0]          row_a,
  input  logic [mroe_pkg::ROW_W-1:0]          row_b,
  input  logic [mroe_pkg::COL_W-1:0]          col,
  input  logic signed [mroe_pkg::DATA_W-1:0]  value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [mroe_pkg::DATA_W-1:0]  read_value,
  output logic                                status
);
  import mroe_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW = $clog2(DEPTH);
  localparam int NC_W = $clog2(MAX_COLS + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_RDATA,
    S_SW_RD,
    S_SW_WA,
    S_SW_WB,
    S_SC_RD,
    S_SC_MUL,
    S_SC_WR,
    S_DONE
  } state_t;

  state_t state;

  logic [CFG_W-1:0]  rows_in_use;
  logic [CFG_W-1:0]  cols_in_use;
  logic [ROW_W-1:0]  cur_a;
  logic [ROW_W-1:0]  cur_b;
  logic [DATA_W-1:0] mult;
  logic [NC_W-1:0]   nc;
  logic [NC_W-1:0]   k;
  logic [DATA_W-1:0] hold;
  logic [DATA_W-1:0] res_value;
  logic              res_status;

  logic              accept;
  logic              out_load;
  logic [NC_W-1:0]   nc_eff;
  logic              ra_ok;
  logic              rb_ok;
  logic              col_ok;
  logic              last_col;
  logic [NC_W-1:0]   kk;

  logic              mem_we;
  logic [AW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;
  logic [AW-1:0]     raddr0;
  logic [AW-1:0]     raddr1;
  logic [DATA_W-1:0] q0;
  logic [DATA_W-1:0] q1;
  logic signed [DATA_W-1:0] scaled;

  function automatic logic [AW-1:0] elem_addr(input logic [ROW_W-1:0] r,
                                              input logic [NC_W-1:0] c);
    elem_addr = AW'(32'(r) * MAX_COLS + 32'(c));
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= ROWS_RESET;
      cols_in_use <= COLS_RESET;
    end else if (cfg_write) begin
      case (reg_idx_t'(cfg_index))
        REG_ROWS: rows_in_use <= cfg_data;
        REG_COLS: cols_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = (state != S_IDLE);
  assign accept = in_valid && !in_stall;
  // finished result moves into the output register when that is free
  assign out_load = (state == S_DONE) && (!out_valid || !out_stall);

  // sizes above the store saturate at the store's dimensions
  assign nc_eff = (32'(cols_in_use) > MAX_COLS) ? NC_W'(MAX_COLS) : NC_W'(cols_in_use);
  assign ra_ok  = (32'(row_a) < 32'(rows_in_use)) && (32'(row_a) < MAX_ROWS);
  assign rb_ok  = (32'(row_b) < 32'(rows_in_use)) && (32'(row_b) < MAX_ROWS);
  assign col_ok = 32'(col) < 32'(nc_eff);

  assign last_col = (k + NC_W'(1)) == nc;
  // write-back states also fetch the next column
  assign kk = ((state == S_SW_WB) || (state == S_SC_WR)) ? k + NC_W'(1) : k;

  assign raddr0 = (state == S_IDLE) ? elem_addr(row_a, NC_W'(col)) : elem_addr(cur_a, kk);
  assign raddr1 = elem_addr(cur_b, kk);

  always_comb begin
    mem_we = 1'b0;
    waddr  = elem_addr(cur_a, k);
    wdata  = hold;
    case (state)
      S_IDLE: begin
        if (accept && (op_t'(op) == OP_WRITE) && ra_ok && col_ok) begin
          mem_we = 1'b1;
          waddr  = elem_addr(row_a, NC_W'(col));
          wdata  = value;
        end
      end
      S_SW_WA: begin
        mem_we = 1'b1;
        wdata  = q1;
      end
      S_SW_WB: begin
        mem_we = 1'b1;
        waddr  = elem_addr(cur_b, k);
      end
      S_SC_WR: begin
        mem_we = 1'b1;
        wdata  = scaled;
      end
      default: ;
    endcase
  end

  mroe_mem #(
    .DEPTH(DEPTH),
    .AW(AW)
  ) u_mem (
    .clk(clk),
    .we(mem_we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr0(raddr0),
    .raddr1(raddr1),
    .q0(q0),
    .q1(q1)
  );

  mroe_mul u_mul (
    .clk(clk),
    .elem($signed(q0)),
    .mult($signed(mult)),
    .scaled(scaled)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid  <= 1'b1;
        read_value <= res_value;
        status     <= res_status;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            cur_a      <= row_a;
            cur_b      <= row_b;
            mult       <= value;
            nc         <= nc_eff;
            k          <= '0;
            res_value  <= '0;
            res_status <= 1'b0;
            case (op_t'(op))
              OP_WRITE: begin
                res_status <= !(ra_ok && col_ok);
                state      <= S_DONE;
              end
              OP_READ: begin
                if (ra_ok && col_ok) begin
                  state <= S_RDATA;
                end else begin
                  res_status <= 1'b1;
                  state      <= S_DONE;
                end
              end
              OP_SWAP: begin
                if (!(ra_ok && rb_ok)) begin
                  res_status <= 1'b1;
                  state      <= S_DONE;
                end else if (nc_eff == '0) begin
                  state <= S_DONE;
                end else begin
                  state <= S_SW_RD;
                end
              end
              OP_SCALE: begin
                if (!ra_ok) begin
                  res_status <= 1'b1;
                  state      <= S_DONE;
                end else if (nc_eff == '0) begin
                  state <= S_DONE;
                end else begin
                  state <= S_SC_RD;
                end
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_RDATA: begin
          res_value <= q0;
          state     <= S_DONE;
        end
        S_SW_RD: state <= S_SW_WA;
        S_SW_WA: begin
          hold  <= q0;
          state <= S_SW_WB;
        end
        S_SW_WB: begin
          if (last_col) begin
            state <= S_DONE;
          end else begin
            k     <= k + NC_W'(1);
            state <= S_SW_WA;
          end
        end
        S_SC_RD: state <= S_SC_MUL;
        S_SC_MUL: state <= S_SC_WR;
        S_SC_WR: begin
          if (last_col) begin
            state <= S_DONE;
          end else begin
            k     <= k + NC_W'(1);
            state <= S_SC_MUL;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result presented without a finished operation");

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SW_WA || state == S_SW_WB || state == S_SC_MUL || state == S_SC_WR)
      |-> k < nc)
    else $error("column counter past columns in use");

  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> read_value == '0)
    else $error("flagged result carries data");

  a_write_when_owned: assert property (@(posedge clk) disable iff (rst)
    (mem_we && state == S_IDLE) |-> (accept && op_t'(op) == OP_WRITE))
    else $error("store written without a write operation");

endmodule

@@ bench/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mroe_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int SETTLE_CYCLES = 3 + 2 * MAX_COLS_DEF + 10;
  localparam int IDLE_PCT = 26;

  typedef enum logic [1:0] {
    ENT_OP,
    ENT_CFG,
    ENT_DRAIN
  } ent_kind_t;

  typedef struct {
    ent_kind_t         kind;
    op_t               opc;
    logic [ROW_W-1:0]  ra;
    logic [ROW_W-1:0]  rb;
    logic [COL_W-1:0]  c;
    logic [DATA_W-1:0] val;
    logic              quiet;
    reg_idx_t          idx;
    logic [CFG_W-1:0]  size;
  } op_entry_t;

  typedef struct {
    logic [DATA_W-1:0] rd;
    logic              st;
  } answer_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_W-1:0]          cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [1:0]                op = '0;
  logic [ROW_W-1:0]          row_a = '0;
  logic [ROW_W-1:0]          row_b = '0;
  logic [COL_W-1:0]          col = '0;
  logic signed [DATA_W-1:0]  value = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [DATA_W-1:0]  read_value;
  logic                      status;

  // shadow copy of the matrix and of the size registers
  logic [DATA_W-1:0] mat_shadow [MAX_ROWS_DEF*MAX_COLS_DEF];
  logic [CFG_W-1:0]  rows_reg = ROWS_RESET;
  logic [CFG_W-1:0]  cols_reg = COLS_RESET;

  op_entry_t op_queue[$];
  answer_t   answer_q[$];
  int        mismatch_count = 0;
  int        cycle_count = 0;
  logic      quiet_now = 1'b0;

  matrix_row_operation_engine_top dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .row_a      (row_a),
    .row_b      (row_b),
    .col        (col),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_value (read_value),
    .status     (status)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int clip(logic [CFG_W-1:0] n, int cap);
    return (int'(n) > cap) ? cap : int'(n);
  endfunction

  function automatic logic [DATA_W-1:0] scale_q16(logic [DATA_W-1:0] e, logic [DATA_W-1:0] m);
    longint p;
    longint q;
    p = longint'($signed(e)) * longint'($signed(m));
    q = p >>> 16;
    if (q > 64'sd2147483647)
      q = 64'sd2147483647;
    else if (q < -64'sd2147483648)
      q = -64'sd2147483648;
    return q[DATA_W-1:0];
  endfunction

  task automatic do_row_op(op_t opc, logic [ROW_W-1:0] ra, logic [ROW_W-1:0] rb,
                           logic [COL_W-1:0] c, logic [DATA_W-1:0] val);
    int nr;
    int nc;
    int base_a;
    int base_b;
    answer_t a;
    logic [DATA_W-1:0] t;
    nr = clip(rows_reg, MAX_ROWS_DEF);
    nc = clip(cols_reg, MAX_COLS_DEF);
    base_a = int'(ra) * MAX_COLS_DEF;
    base_b = int'(rb) * MAX_COLS_DEF;
    a.rd = '0;
    a.st = 1'b0;
    case (opc)
      OP_WRITE, OP_READ: begin
        if (int'(ra) >= nr || int'(c) >= nc) begin
          a.st = 1'b1;
        end else if (opc == OP_WRITE) begin
          mat_shadow[base_a + int'(c)] = val;
        end else begin
          a.rd = mat_shadow[base_a + int'(c)];
        end
      end
      OP_SWAP: begin
        if (int'(ra) >= nr || int'(rb) >= nr) begin
          a.st = 1'b1;
        end else begin
          for (int k = 0; k < nc; k++) begin
            t = mat_shadow[base_a + k];
            mat_shadow[base_a + k] = mat_shadow[base_b + k];
            mat_shadow[base_b + k] = t;
          end
        end
      end
      default: begin
        if (int'(ra) >= nr) begin
          a.st = 1'b1;
        end else begin
          for (int k = 0; k < nc; k++)
            mat_shadow[base_a + k] = scale_q16(mat_shadow[base_a + k], val);
        end
      end
    endcase
    answer_q.push_back(a);
  endtask

  task automatic report(string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  // stimulus helpers
  function automatic logic [DATA_W-1:0] rand_word();
    int pick;
    logic [DATA_W-1:0] s;
    pick = $urandom_range(99);
    s = $urandom_range(32'h3FFFF);
    if (pick < 12) begin
      case ($urandom_range(3))
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0000;
        2: return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    if (pick < 30)
      return $urandom_range(1) ? -s : s;
    return $urandom();
  endfunction

  function automatic int pick_index(int n);
    if (n > 0 && $urandom_range(99) < 88)
      return $urandom_range(n - 1);
    return $urandom_range(15);
  endfunction

  task automatic push_op(op_t opc, int ra, int rb, int c, logic [DATA_W-1:0] v);
    op_entry_t e;
    e.kind = ENT_OP;
    e.opc = opc;
    e.ra = ROW_W'(ra);
    e.rb = ROW_W'(rb);
    e.c = COL_W'(c);
    e.val = v;
    e.quiet = 1'b0;
    e.idx = REG_ROWS;
    e.size = '0;
    op_queue.push_back(e);
  endtask

  task automatic push_sizes(int rows, int cols);
    op_entry_t e;
    e.kind = ENT_CFG;
    e.opc = OP_WRITE;
    e.ra = '0;
    e.rb = '0;
    e.c = '0;
    e.val = '0;
    e.quiet = 1'b0;
    e.idx = REG_ROWS;
    e.size = CFG_W'(rows);
    op_queue.push_back(e);
    e.idx = REG_COLS;
    e.size = CFG_W'(cols);
    op_queue.push_back(e);
  endtask

  task automatic random_phase(int rows, int cols, int n, int quiet_lo, int quiet_hi);
    op_entry_t e;
    int nr;
    int nc;
    logic [DATA_W-1:0] m;
    nr = (rows > MAX_ROWS_DEF) ? MAX_ROWS_DEF : rows;
    nc = (cols > MAX_COLS_DEF) ? MAX_COLS_DEF : cols;
    push_sizes(rows, cols);
    for (int i = 0; i < n; i++) begin
      e.kind = ENT_OP;
      e.opc = op_t'($urandom_range(3));
      e.ra = ROW_W'(pick_index(nr));
      e.rb = ROW_W'(pick_index(nr));
      e.c = COL_W'(pick_index(nc));
      e.val = rand_word();
      if (e.opc == OP_SCALE && $urandom_range(99) < 45) begin
        // multipliers near one keep the row away from saturation
        m = 32'h8000 + $urandom_range(32'h10000);
        e.val = $urandom_range(1) ? -m : m;
      end
      e.quiet = (i >= quiet_lo && i < quiet_hi);
      e.idx = REG_ROWS;
      e.size = '0;
      op_queue.push_back(e);
      if (i == n / 2) begin
        e.kind = ENT_DRAIN;
        op_queue.push_back(e);
      end
    end
  endtask

  // sender: one transaction per queued operation, size writes only when idle
  always @(posedge clk) begin : drive_ops
    op_entry_t head;
    logic keep;
    logic nxt_cfg;
    keep = in_valid && in_stall;
    nxt_cfg = 1'b0;
    if (!rst) begin
      if (in_valid && !in_stall)
        do_row_op(op_t'(op), row_a, row_b, col, value);
      if (!keep && op_queue.size() != 0) begin
        head = op_queue[0];
        case (head.kind)
          ENT_OP: begin
            if (head.quiet || $urandom_range(99) >= IDLE_PCT) begin
              keep = 1'b1;
              op <= head.opc;
              row_a <= head.ra;
              row_b <= head.rb;
              col <= head.c;
              value <= head.val;
              quiet_now <= head.quiet;
              void'(op_queue.pop_front());
            end
          end
          ENT_CFG: begin
            if (answer_q.size() == 0) begin
              nxt_cfg = 1'b1;
              cfg_index <= head.idx;
              cfg_data <= head.size;
              if (head.idx == REG_ROWS)
                rows_reg = head.size;
              else
                cols_reg = head.size;
              void'(op_queue.pop_front());
            end
          end
          default: begin
            if (answer_q.size() == 0)
              void'(op_queue.pop_front());
          end
        endcase
      end
    end
    in_valid <= keep;
    cfg_write <= nxt_cfg;
  end

  // receiver: check each result transaction against the oldest answer
  always @(posedge clk) begin : check_results
    answer_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (answer_q.size() == 0) begin
          report($sformatf("result with no operation waiting (read_value %h status %b)",
                           read_value, status));
        end else begin
          want = answer_q.pop_front();
          if (read_value !== want.rd)
            report($sformatf("read_value %h, want %h", read_value, want.rd));
          if (status !== want.st)
            report($sformatf("status %b, want %b", status, want.st));
        end
      end
      out_stall <= !quiet_now && ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAIL matrix_row_operation_engine_top");
      $finish;
    end
  end

  initial begin
    int extra_rows;
    int extra_cols;
    // every entry gets written first, so later reads, swaps and scales are legal
    for (int r = 0; r < MAX_ROWS_DEF; r++)
      for (int c = 0; c < MAX_COLS_DEF; c++)
        push_op(OP_WRITE, r, 0, c, rand_word());

    // extremes, row 15 / column 15 corners, swap with itself
    push_op(OP_WRITE, 0, 0, 0, 32'h7FFF_FFFF);
    push_op(OP_READ, 0, 0, 0, '0);
    push_op(OP_WRITE, 15, 0, 15, 32'h8000_0000);
    push_op(OP_READ, 15, 0, 15, '0);
    push_op(OP_SWAP, 0, 15, 0, '0);
    push_op(OP_READ, 0, 0, 15, '0);
    push_op(OP_SWAP, 7, 7, 0, '0);
    // scale by one, minus one, the smallest step, and saturation both ways
    push_op(OP_WRITE, 2, 0, 5, 32'h0003_0000);
    push_op(OP_SCALE, 2, 0, 0, 32'h0001_0000);
    push_op(OP_SCALE, 2, 0, 0, 32'hFFFF_0000);
    push_op(OP_SCALE, 2, 0, 0, 32'h0000_0001);
    push_op(OP_READ, 2, 0, 5, '0);
    push_op(OP_WRITE, 3, 0, 0, 32'h7FFF_FFFF);
    push_op(OP_SCALE, 3, 0, 0, 32'h7FFF_FFFF);
    push_op(OP_READ, 3, 0, 0, '0);
    push_op(OP_SCALE, 3, 0, 0, 32'h8000_0000);
    push_op(OP_READ, 3, 0, 0, '0);
    push_op(OP_SCALE, 4, 0, 0, 32'h0000_0000);
    push_op(OP_READ, 4, 0, 9, '0);
    // out of range rows and columns under reduced sizes
    push_sizes(4, 3);
    push_op(OP_WRITE, 4, 0, 0, 32'h1234_5678);
    push_op(OP_READ, 0, 0, 3, '0);
    push_op(OP_SWAP, 1, 4, 0, '0);
    push_op(OP_SWAP, 4, 1, 0, '0);
    push_op(OP_SCALE, 4, 0, 0, 32'h0002_0000);
    push_op(OP_SCALE, 3, 0, 0, 32'h0002_0000);
    push_op(OP_READ, 3, 0, 2, '0);
    // zero sizes flag everything, oversized ones act as full size
    push_sizes(0, 0);
    push_op(OP_WRITE, 0, 0, 0, 32'h0000_0001);
    push_op(OP_SWAP, 0, 0, 0, '0);
    push_op(OP_SCALE, 0, 0, 0, 32'h0001_0000);
    push_sizes(31, 31);
    push_op(OP_READ, 15, 0, 15, '0);
    push_op(OP_SWAP, 0, 15, 0, '0);

    random_phase(16, 16, 520, 200, 400);
    random_phase(1, 1, 60, 0, 0);
    random_phase(0, 7, 40, 0, 0);
    random_phase(9, 0, 40, 0, 0);
    random_phase(31, 17, 150, 0, 0);
    random_phase(5, 11, 150, 0, 0);
    random_phase(16, 1, 100, 0, 0);
    random_phase(2, 16, 100, 0, 0);
    random_phase(13, 3, 100, 0, 0);
    for (int p = 0; p < 3; p++) begin
      extra_rows = $urandom_range(31);
      extra_cols = $urandom_range(31);
      random_phase(extra_rows, extra_cols, 100, 0, 0);
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    do
      @(negedge clk);
    while (op_queue.size() != 0 || in_valid || answer_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0)
      $display("PASS matrix_row_operation_engine_top");
    else
      $display("FAIL matrix_row_operation_engine_top");
    $finish;
  end

endmodule

@@ files.f @@
rtl/mroe_pkg.sv
rtl/mroe_mem.sv
rtl/mroe_mul.sv
rtl/matrix_row_operation_engine_top.sv
bench/tb_top.sv
